FILE: rtl/otct_pkg.sv
package otct_pkg;

  // Table geometry
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Request and response field widths
  localparam int NONCE_W  = 64;
  localparam int ID_W     = 256;
  localparam int WORD_W   = NONCE_W + ID_W;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0] idx_t;

endpackage

FILE: rtl/otct_ram.sv
module otct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/one_time_challenge_table.sv
// One-time challenge table. Holds up to ENTRIES outstanding challenges, each
// a 64-bit nonce bound to a 256-bit identity digest (id_word0 is the most
// significant word). A store request (req_type bit 0 low) puts the pair in the
// lowest free slot and answers ST_OK, or ST_FULL when no slot is free. A
// verify request (req_type bit 0 high) scans the slots in ascending order,
// frees the lowest active slot whose nonce and digest both match and answers
// ST_OK, or ST_NOT_FOUND. Every request gives exactly one response, carrying
// the active-entry count after the request. Requests are handled one at a
// time: a store goes through S_FINISH to the output register, a verify
// through S_SCAN and S_FINISH; the scan reads one entry per cycle through
// the read port of the slot memory and stops at the first hit. A finished
// response waits in the output register, so the next request can be taken
// while the previous response is still stalled. Slot valid bits live in
// flip-flops cleared by reset; the slot memory itself needs no clearing pass.
module one_time_challenge_table
  import otct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [NONCE_W-1:0]  nonce,
  input  logic [63:0]         id_word0,
  input  logic [63:0]         id_word1,
  input  logic [63:0]         id_word2,
  input  logic [63:0]         id_word3,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  active_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t              state;
  logic [ENTRIES-1:0]  entry_valid;
  logic [CNT_W-1:0]    live_count;

  // request held during the scan
  logic [WORD_W-1:0]   req_word;

  // scan pipeline: ptr is the address issued, cmp_idx the entry whose data
  // is on the memory output this cycle
  idx_t                ptr;
  idx_t                cmp_idx;
  logic                cmp_vld;

  // pending response
  status_t             res_status;

  // output register
  status_t             out_status;
  logic [COUNT_W-1:0]  out_count;

  logic                accept;
  logic                is_store;
  logic                free_found;
  idx_t                free_idx;
  logic [WORD_W-1:0]   in_word;
  logic [WORD_W-1:0]   rd_word;
  idx_t                rd_addr;
  logic                mem_we;
  logic                hit;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_store = !req_type;
  assign in_word  = {nonce, id_word0, id_word1, id_word2, id_word3};
  assign out_free = !out_valid || !out_stall;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign mem_we  = accept && is_store && free_found;
  assign rd_addr = ptr;

  otct_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(free_idx),
    .wdata(in_word),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

  // freed slots keep stale data, so the valid bit gates the compare
  assign hit = (state == S_SCAN) && cmp_vld && entry_valid[cmp_idx] && (rd_word == req_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      live_count  <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_word <= in_word;
            if (is_store) begin
              if (free_found) begin
                entry_valid[free_idx] <= 1'b1;
                live_count            <= live_count + CNT_W'(1);
                res_status            <= ST_OK;
              end else begin
                res_status <= ST_FULL;
              end
              state <= S_FINISH;
            end else begin
              ptr     <= '0;
              cmp_vld <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          cmp_idx <= ptr;
          cmp_vld <= 1'b1;
          if (ptr != LAST_IDX) begin
            ptr <= ptr + IDX_W'(1);
          end
          if (hit) begin
            entry_valid[cmp_idx] <= 1'b0;
            if (live_count != '0) begin
              live_count <= live_count - CNT_W'(1);
            end
            res_status <= ST_OK;
            cmp_vld    <= 1'b0;
            state      <= S_FINISH;
          end else if (cmp_vld && cmp_idx == LAST_IDX) begin
            res_status <= ST_NOT_FOUND;
            cmp_vld    <= 1'b0;
            state      <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= COUNT_W'(live_count);
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status       = out_status;
  assign active_count = out_count;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(live_count) == $countones(entry_valid))
    else $error("live count disagrees with slot valid bits");

  a_hit_frees_slot: assert property (@(posedge clk) disable iff (rst)
    hit |=> !entry_valid[$past(cmp_idx)])
    else $error("matched slot not freed");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (accept && is_store && !free_found) |-> (&entry_valid))
    else $error("store reported full with a free slot");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_NOT_FOUND))
    else $error("illegal response status");

  a_one_result_per_request: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished request not delivered");
`endif

endmodule
